>>> sv/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int WORD_W = 32;
    localparam int BIT_W = $clog2(WORD_W);
    localparam int OP_W = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int BYTE_W = COUNT_W - 3;
    localparam int MAX_SEARCH_BLOCKS = 1 << INDEX_W;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd2;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [INDEX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] allocated_block;
        logic status;
    } res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic rd;
        logic wr;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
    } stat_t;

endpackage
`default_nettype wire

>>> sv/bitmap_block_allocator_core.sv
`default_nettype none
// channel   ports                      handshake
// request   request (req_t)            taken when start && !busy
// result    result (res_t)             valid while done is high, one cycle
// config    cfg_we, cfg_data           written when cfg_we is high
//
// every request goes through accept, map word read and read-modify-write;
// the result shows on done in the cycle after, when busy is already low
// allocate picks a word from the full-word summary, then encodes inside the word
// after reset the map is zeroed one word a cycle and busy stays high until
// every word is clear; config writes are taken throughout
// the receiver cannot stall, results are not held
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    input  wire req_t request,
    output logic done,
    output res_t result,
    input  wire logic cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    cmd_t cmd;
    stat_t stat;

    bba_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .stat(stat),
        .busy(busy),
        .cmd(cmd)
    );

    bba_datapath #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .stat(stat),
        .request(request),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .done(done),
        .result(result)
    );

endmodule
`default_nettype wire

>>> sv/bba_ctrl.sv
`default_nettype none
module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire stat_t stat,
    output logic busy,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.accept = start;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.wr = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/bba_datapath.sv
`default_nettype none
module bba_datapath
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    output stat_t stat,
    input  wire req_t request,
    input  wire logic cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_data,
    output logic done,
    output res_t result
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int MAX_SEARCH_WORDS = MAX_SEARCH_BLOCKS / WORD_W;
    localparam int SEARCH_WORDS = (NUM_WORDS < MAX_SEARCH_WORDS) ? NUM_WORDS : MAX_SEARCH_WORDS;
    localparam int SW_W = (SEARCH_WORDS > 1) ? $clog2(SEARCH_WORDS) : 1;
    localparam int LIMIT_BYTES = NUM_BLOCKS / 8;
    localparam int FOUND_W = WADDR_W + BIT_W;

    logic [WORD_W-1:0] mem [NUM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [SEARCH_WORDS-1:0] full_reg;
    logic [WADDR_W-1:0] clear_cnt_reg;
    logic [WADDR_W-1:0] addr_reg;
    logic [WADDR_W-1:0] addr_next;
    logic [OP_W-1:0] op_reg;
    logic [BIT_W-1:0] bit_reg;
    logic in_range_reg;
    logic cand_valid_reg;
    logic [BYTE_W-1:0] lim_bytes_reg;
    logic [BYTE_W-1:0] lim_bytes_next;
    logic done_reg;
    res_t result_reg;

    logic [SW_W-1:0] cand_word;
    logic cand_valid;
    logic [BIT_W-1:0] zero_bit;
    logic zero_found;
    logic [FOUND_W-1:0] found;
    logic hit;
    logic is_alloc;
    logic we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] mod_word;

    // lowest word that still has a free block
    always_comb
    begin
        cand_word = '0;
        cand_valid = 1'b0;
        for (int i = SEARCH_WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                cand_word = SW_W'(i);
                cand_valid = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (request.operation == OP_ALLOCATE)
        begin
            addr_next = WADDR_W'(cand_word);
        end
        else
        begin
            addr_next = WADDR_W'(request.block_index >> BIT_W);
        end
        lim_bytes_next = count_reg[COUNT_W-1:3];
        if (32'(count_reg[COUNT_W-1:3]) > LIMIT_BYTES)
        begin
            lim_bytes_next = BYTE_W'(LIMIT_BYTES);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= addr_next;
            op_reg <= request.operation;
            bit_reg <= request.block_index[BIT_W-1:0];
            in_range_reg <= (32'(request.block_index) < NUM_BLOCKS);
            cand_valid_reg <= cand_valid;
            lim_bytes_reg <= lim_bytes_next;
        end
    end

    // lowest clear bit of the word read back
    always_comb
    begin
        zero_bit = '0;
        zero_found = 1'b0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (!rdata_reg[k])
            begin
                zero_bit = BIT_W'(k);
                zero_found = 1'b1;
            end
        end
    end

    assign found = {addr_reg, zero_bit};
    assign is_alloc = (op_reg == OP_ALLOCATE);
    // blocks of a trailing partial byte or past the store fail the byte limit
    assign hit = cand_valid_reg && zero_found && ((32'(found) >> 3) < 32'(lim_bytes_reg));

    always_comb
    begin
        mod_word = rdata_reg;
        we = 1'b0;
        case (op_reg)
            OP_ALLOCATE:
            begin
                mod_word = rdata_reg | (WORD_W'(1) << zero_bit);
                we = cmd.wr && hit;
            end
            OP_FREE:
            begin
                mod_word = rdata_reg & ~(WORD_W'(1) << bit_reg);
                we = cmd.wr && in_range_reg;
            end
            OP_MARK_USED:
            begin
                mod_word = rdata_reg | (WORD_W'(1) << bit_reg);
                we = cmd.wr && in_range_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign waddr = cmd.clear ? clear_cnt_reg : addr_reg;
    assign wdata = cmd.clear ? '0 : mod_word;

    always_ff @(posedge clk)
    begin
        if (cmd.clear || we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            full_reg <= '0;
            clear_cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (we && (32'(addr_reg) < SEARCH_WORDS))
            begin
                full_reg[addr_reg[SW_W-1:0]] <= &mod_word;
            end
            if (cmd.clear)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            done_reg <= cmd.wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            result_reg.allocated_block <= (is_alloc && hit) ? INDEX_W'(found) : '0;
            result_reg.status <= (is_alloc && !hit) ? STATUS_NO_FREE : STATUS_OK;
        end
    end

    assign stat.clear_done = cmd.clear && (clear_cnt_reg == WADDR_W'(NUM_WORDS - 1));
    assign done = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

>>> sv/bba_checker.sv
`default_nettype none
module bba_checker
    import bba_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire req_t request,
    input wire logic done,
    input wire res_t result
);

    // a result always comes back with the block free for a new request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result not three cycles after request");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.allocated_block == '0))
        else $error("failed allocate with non-zero block");

    // only allocate can report no free block
    a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy, 3) && ($past(request.operation, 3) != OP_ALLOCATE))
        |-> (result.status == STATUS_OK))
        else $error("status set on free or mark used");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
);
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
module tb_top;
    import bba_pkg::*;

    localparam int MAP_SIZE = NUM_BLOCKS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT = 600;

    typedef struct {
        req_t req;
        int gap;
    } queued_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    res_t result;
    logic cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;

    // model of the block: one used bit per data block and the block count
    bit block_used [MAP_SIZE];
    logic [COUNT_W-1:0] block_count = COUNT_RESET;

    queued_req_t request_queue [$];
    res_t results_due [$];
    int idle_cycles = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;
    bit no_idle = 1'b0;

    bitmap_block_allocator_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic res_t apply_to_map(req_t r);
        res_t res;
        int search_bytes;
        res = '0;
        res.status = STATUS_OK;
        case (r.operation)
            OP_ALLOCATE:
            begin
                // only whole bytes are searched, capped at the map size
                search_bytes = int'(block_count) / 8;
                if (search_bytes > MAP_SIZE / 8)
                    search_bytes = MAP_SIZE / 8;
                res.status = STATUS_NO_FREE;
                for (int i = 0; i < search_bytes * 8; i++)
                begin
                    if (!block_used[i])
                    begin
                        block_used[i] = 1'b1;
                        res.allocated_block = i[INDEX_W-1:0];
                        res.status = STATUS_OK;
                        break;
                    end
                end
            end
            OP_FREE:
                block_used[r.block_index] = 1'b0;
            OP_MARK_USED:
                block_used[r.block_index] = 1'b1;
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic add_request(input logic [OP_W-1:0] op, input int idx);
        queued_req_t q;
        q.req.operation = op;
        q.req.block_index = idx[INDEX_W-1:0];
        q.gap = draw_gap();
        request_queue.push_back(q);
    endtask

    // sender pauses here until every result has come back
    task automatic drain();
        while (request_queue.size() != 0 || results_due.size() != 0 || start)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value[COUNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        block_count = value[COUNT_W-1:0];
    endtask

    task automatic queue_random_phase(input int n, input int count, input bit alloc_heavy);
        int r;
        int idx;
        int hi;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            hi = (count + 7 > MAP_SIZE - 1) ? MAP_SIZE - 1 : count + 7;
            if ($urandom_range(0, 3) == 0)
                idx = $urandom_range(0, MAP_SIZE - 1);
            else
                idx = $urandom_range(0, hi);
            if (alloc_heavy && r < 85)
                add_request(OP_ALLOCATE, $urandom_range(0, MAP_SIZE - 1));
            else if (r < 50)
                add_request(OP_ALLOCATE, $urandom_range(0, MAP_SIZE - 1));
            else if (r < 75)
                add_request(OP_FREE, idx);
            else if (r < 95)
                add_request(OP_MARK_USED, idx);
            else
                add_request(OP_UNUSED, idx);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        logic taken;
        logic start_next;
        queued_req_t q;
        taken = 1'b0;
        start_next = start;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                results_due.push_back(apply_to_map(request));
                taken = 1'b1;
            end
            if (!start || taken)
            begin
                if (request_queue.size() != 0 && idle_cycles >= request_queue[0].gap)
                begin
                    q = request_queue.pop_front();
                    request <= q.req;
                    start_next = 1'b1;
                    idle_cycles = 0;
                end
                else
                begin
                    start_next = 1'b0;
                    idle_cycles++;
                end
            end
            start <= start_next;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: block %0d status %0b",
                             result.allocated_block, result.status);
            end
            else
            begin
                want = results_due.pop_front();
                if (result.allocated_block !== want.allocated_block
                    || result.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: block exp %0d got %0d, status exp %0b got %0b",
                                 want.allocated_block, result.allocated_block,
                                 want.status, result.status);
                end
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int issued;
        int n;
        int count;
        bit heavy;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default count, empty map
        add_request(OP_ALLOCATE, MAP_SIZE - 1);
        add_request(OP_ALLOCATE, 0);
        add_request(OP_ALLOCATE, 'h2AA);
        add_request(OP_MARK_USED, 3);
        add_request(OP_ALLOCATE, 0);
        add_request(OP_FREE, 1);
        add_request(OP_ALLOCATE, 'h155);
        add_request(OP_UNUSED, MAP_SIZE - 1);
        add_request(OP_UNUSED, 0);
        add_request(OP_MARK_USED, MAP_SIZE - 1);
        add_request(OP_FREE, MAP_SIZE - 1);
        add_request(OP_FREE, 0);
        add_request(OP_ALLOCATE, 0);
        add_request(OP_MARK_USED, 0);
        drain();

        // zero count: nothing can be granted
        write_count(0);
        add_request(OP_ALLOCATE, 0);
        add_request(OP_MARK_USED, 5);
        drain();

        // below one whole byte
        write_count(7);
        add_request(OP_ALLOCATE, 0);
        drain();

        // trailing partial byte is never granted
        write_count(13);
        repeat (4) add_request(OP_ALLOCATE, 0);
        drain();

        // count above the map saturates
        write_count(2047);
        add_request(OP_ALLOCATE, 0);
        add_request(OP_ALLOCATE, 0);
        drain();

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: count = $urandom_range(0, 7);
                1, 2: count = $urandom_range(8, 80);
                3: count = 1024;
                4: count = 2047;
                5: count = $urandom_range(1025, 2046);
                default: count = $urandom_range(0, 2047);
            endcase
            n = $urandom_range(30, 90);
            if (n > RANDOM_ITEMS - issued)
                n = RANDOM_ITEMS - issued;
            heavy = ($urandom_range(0, 4) == 0);
            no_idle = ($urandom_range(0, 3) == 0);
            write_count(count);
            queue_random_phase(n, count, heavy);
            issued += n;
            drain();
        end

        repeat (10) @(posedge clk);
        if (results_due.size() != 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0d results never arrived", results_due.size());
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
